// ===== hdl/trp_pkg.sv =====
// Package with shared constants, types and register codes of the ramp path time unit.
`timescale 1ns / 1ps
package trp_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int REG_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int SEG_LEN_W  = 34;
	localparam int SEG_TIME_W = 48;
	localparam int SUM_W      = 63;
	localparam int COUNT_W    = 32;
	localparam int OUT_W      = SEG_LEN_W + SEG_TIME_W + 2 * SUM_W + COUNT_W;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = 1'b1;

	localparam logic [REG_W-1:0] REG_RESET = 32'd65536;

	typedef struct packed {
		logic seg;
		logic start;
		logic last;
	} trp_flags_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_MDA,
		ST_MVV,
		ST_DIVS,
		ST_ROOTS,
		ST_DIV1,
		ST_DIV2,
		ST_FIN
	} bk_state_t;

endpackage

// ===== hdl/trp_front.sv =====
// Front end: accepts waypoints, forms coordinate differences and queues them.
`timescale 1ns / 1ps
module trp_front #(
	parameter int COORD_BITS = trp_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic                  path_start,
	input  logic                  path_end,
	output logic                  q_valid,
	input  logic                  q_pop,
	output logic [COORD_BITS-1:0] q_dx,
	output logic [COORD_BITS-1:0] q_dy,
	output trp_pkg::trp_flags_t   q_flags
);
	import trp_pkg::*;

	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic                  have_prev_q;
	logic [COORD_BITS-1:0] dx_mem [2];
	logic [COORD_BITS-1:0] dy_mem [2];
	trp_flags_t            fl_mem [2];
	logic                  wr_ptr_q, rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  accept;
	logic signed [COORD_BITS:0] diff_x, diff_y;
	logic [COORD_BITS:0]   mag_x, mag_y;
	trp_flags_t            fl_new;

	assign in_ready = (cnt_q != 2'd2);
	assign accept   = in_valid & in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_dx     = dx_mem[rd_ptr_q];
	assign q_dy     = dy_mem[rd_ptr_q];
	assign q_flags  = fl_mem[rd_ptr_q];

	always_comb begin
		diff_x = $signed({point_x[COORD_BITS-1], point_x})
			- $signed({prev_x_q[COORD_BITS-1], prev_x_q});
		diff_y = $signed({point_y[COORD_BITS-1], point_y})
			- $signed({prev_y_q[COORD_BITS-1], prev_y_q});
		mag_x = diff_x[COORD_BITS] ? $unsigned(-diff_x) : $unsigned(diff_x);
		mag_y = diff_y[COORD_BITS] ? $unsigned(-diff_y) : $unsigned(diff_y);
		fl_new.seg   = have_prev_q & ~path_start;
		fl_new.start = path_start;
		fl_new.last  = path_end;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_mem[wr_ptr_q] <= mag_x[COORD_BITS-1:0];
			dy_mem[wr_ptr_q] <= mag_y[COORD_BITS-1:0];
			fl_mem[wr_ptr_q] <= fl_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			wr_ptr_q    <= 1'b0;
			rd_ptr_q    <= 1'b0;
			cnt_q       <= 2'd0;
		end else begin
			if (accept) begin
				prev_x_q    <= point_x;
				prev_y_q    <= point_y;
				have_prev_q <= ~path_end;
				wr_ptr_q    <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(accept) - 2'(q_pop);
		end
	end

endmodule

// ===== hdl/trp_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module trp_div #(
	parameter int NW = 68,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q, quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW+1:0] trial;
	logic [DW+1:0] diff;

	assign busy = busy_q;
	assign quo  = quo_q;

	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		diff  = trial - {2'b00, den_q};
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!diff[DW+1]) begin
				rem_q <= diff[DW:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CW'(1));
		end
	end

endmodule

// ===== hdl/trp_sqrt.sv =====
// Digit-by-digit integer square root that retires one root bit per cycle.
`timescale 1ns / 1ps
module trp_sqrt #(
	parameter int XW = 68
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [XW-1:0]    x,
	output logic             busy,
	output logic [XW/2-1:0]  root
);
	localparam int RW = XW / 2;
	localparam int CW = $clog2(RW + 1);

	logic [XW-1:0] x_q;
	logic [RW-1:0] root_q;
	logic [RW+1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [RW+3:0] rem_t, trial, diff;

	assign busy = busy_q;
	assign root = root_q;

	always_comb begin
		rem_t = {rem_q, x_q[XW-1:XW-2]};
		trial = {2'b00, root_q, 2'b01};
		diff  = rem_t - trial;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= x;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			x_q <= x_q << 2;
			if (rem_t >= trial) begin
				rem_q  <= diff[RW+1:0];
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_t[RW+1:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(RW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CW'(1));
		end
	end

endmodule

// ===== hdl/trp_back.sv =====
// Back end: sequences length, ramp time and running totals for each queued waypoint.
`timescale 1ns / 1ps
module trp_back #(
	parameter int COORD_BITS = trp_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = trp_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [trp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [trp_pkg::REG_W-1:0]       cfg_data,
	input  logic                            q_valid,
	output logic                            q_pop,
	input  logic [COORD_BITS-1:0]           q_dx,
	input  logic [COORD_BITS-1:0]           q_dy,
	input  trp_pkg::trp_flags_t             q_flags,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [trp_pkg::SEG_LEN_W-1:0]   segment_length,
	output logic [trp_pkg::SEG_TIME_W-1:0]  segment_time,
	output logic [trp_pkg::SUM_W-1:0]       total_length,
	output logic [trp_pkg::SUM_W-1:0]       total_time,
	output logic [trp_pkg::COUNT_W-1:0]     waypoint_count,
	output logic                            path_done
);
	import trp_pkg::*;

	localparam int MW  = (COORD_BITS > SEG_LEN_W) ? COORD_BITS : SEG_LEN_W;
	localparam int PW  = 2 * MW;
	localparam int MCW = $clog2(MW + 1);
	localparam int NW  = SEG_LEN_W + 2 * FRAC_BITS + 2;
	localparam int SQW = 2 * COORD_BITS + 1;
	localparam int XM  = (SQW > NW) ? SQW : NW;
	localparam int XW  = ((XM + 1) / 2) * 2;
	localparam int RW  = XW / 2;
	localparam int CW  = (RW > SEG_TIME_W) ? RW : SEG_TIME_W;

	localparam logic [CW-1:0] LEN_MAX_C  = CW'({SEG_LEN_W{1'b1}});
	localparam logic [CW-1:0] TIME_MAX_C = CW'({SEG_TIME_W{1'b1}});
	localparam logic [NW-1:0] TIME_MAX_N = NW'({SEG_TIME_W{1'b1}});

	bk_state_t state_q, state_d;
	logic      started_q, op_done, unit_busy;
	logic      mul_go, div_go, sqrt_go, out_load;

	logic [REG_W-1:0]      speed_q, accel_q;
	logic [COORD_BITS-1:0] dx_q, dy_q;
	trp_flags_t            flags_q;
	logic [XW-1:0]         sq_q;
	logic [PW-1:0]         lhs_q;
	logic [SEG_LEN_W-1:0]  len_q;
	logic [SEG_TIME_W-1:0] time_q;
	logic [SUM_W-1:0]      len_sum_q, time_sum_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic                  out_valid_q;

	logic [PW-1:0]  mul_a_q, mul_p_q;
	logic [MW-1:0]  mul_b_q;
	logic [MCW-1:0] mul_cnt_q;
	logic           mul_busy_q;
	logic [MW-1:0]  mul_x, mul_y;

	logic [NW-1:0]    div_num, div_quo;
	logic [REG_W-1:0] div_den;
	logic             div_busy;
	logic [XW-1:0]    sqrt_x;
	logic [RW-1:0]    sqrt_root;
	logic             sqrt_busy;

	logic [CW-1:0]         root_ext;
	logic [SEG_LEN_W-1:0]  len_sat;
	logic [SEG_TIME_W-1:0] root_time_sat, quo_sat;
	logic [SEG_TIME_W:0]   time_add;
	logic [SUM_W-1:0]      len_base, time_base;
	logic [COUNT_W-1:0]    cnt_base;
	logic [SUM_W:0]        len_add, tsum_add;
	logic [COUNT_W:0]      cnt_add;
	logic [SUM_W-1:0]      len_new, tsum_new;
	logic [COUNT_W-1:0]    cnt_new;

	trp_div #(.NW(NW), .DW(REG_W)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(div_num), .den(div_den),
		.busy(div_busy), .quo(div_quo)
	);

	trp_sqrt #(.XW(XW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .go(sqrt_go), .x(sqrt_x),
		.busy(sqrt_busy), .root(sqrt_root)
	);

	assign unit_busy = mul_busy_q | div_busy | sqrt_busy;
	assign op_done   = started_q & ~unit_busy;
	assign out_valid = out_valid_q;

	always_comb begin
		mul_x   = MW'(dx_q);
		mul_y   = MW'(dx_q);
		div_num = {len_q, {(2 * FRAC_BITS + 2){1'b0}}};
		div_den = accel_q;
		sqrt_x  = sq_q;
		unique case (state_q)
			ST_SQY: begin
				mul_x = MW'(dy_q);
				mul_y = MW'(dy_q);
			end
			ST_MDA: begin
				mul_x = MW'(len_q);
				mul_y = MW'(accel_q);
			end
			ST_MVV: begin
				mul_x = MW'(speed_q);
				mul_y = MW'(speed_q);
			end
			ST_DIV1: begin
				div_num = NW'({speed_q, {FRAC_BITS{1'b0}}});
			end
			ST_DIV2: begin
				div_num = NW'({len_q, {FRAC_BITS{1'b0}}});
				div_den = speed_q;
			end
			ST_ROOTS: begin
				sqrt_x = XW'(div_quo);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		root_ext      = CW'(sqrt_root);
		len_sat       = (root_ext > LEN_MAX_C) ? {SEG_LEN_W{1'b1}} : root_ext[SEG_LEN_W-1:0];
		root_time_sat = (root_ext > TIME_MAX_C) ? {SEG_TIME_W{1'b1}}
			: root_ext[SEG_TIME_W-1:0];
		quo_sat       = (div_quo > TIME_MAX_N) ? {SEG_TIME_W{1'b1}} : div_quo[SEG_TIME_W-1:0];
		time_add      = {1'b0, time_q} + {1'b0, quo_sat};

		len_base  = flags_q.start ? '0 : len_sum_q;
		time_base = flags_q.start ? '0 : time_sum_q;
		cnt_base  = flags_q.start ? '0 : cnt_q;
		len_add   = {1'b0, len_base} + (SUM_W + 1)'(len_q);
		tsum_add  = {1'b0, time_base} + (SUM_W + 1)'(time_q);
		cnt_add   = {1'b0, cnt_base} + (COUNT_W + 1)'(1);
		len_new   = len_add[SUM_W] ? {SUM_W{1'b1}} : len_add[SUM_W-1:0];
		tsum_new  = tsum_add[SUM_W] ? {SUM_W{1'b1}} : tsum_add[SUM_W-1:0];
		cnt_new   = cnt_add[COUNT_W] ? {COUNT_W{1'b1}} : cnt_add[COUNT_W-1:0];
	end

	always_comb begin
		state_d  = state_q;
		mul_go   = 1'b0;
		div_go   = 1'b0;
		sqrt_go  = 1'b0;
		q_pop    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = q_flags.seg ? ST_SQX : ST_FIN;
				end
			end
			ST_SQX: begin
				mul_go = ~started_q;
				if (op_done) state_d = ST_SQY;
			end
			ST_SQY: begin
				mul_go = ~started_q;
				if (op_done) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				sqrt_go = ~started_q;
				if (op_done) state_d = ST_MDA;
			end
			ST_MDA: begin
				mul_go = ~started_q;
				if (op_done) state_d = ST_MVV;
			end
			ST_MVV: begin
				mul_go = ~started_q;
				if (op_done) state_d = (mul_p_q > lhs_q) ? ST_DIVS : ST_DIV1;
			end
			ST_DIVS: begin
				div_go = ~started_q;
				if (op_done) state_d = ST_ROOTS;
			end
			ST_ROOTS: begin
				sqrt_go = ~started_q;
				if (op_done) state_d = ST_FIN;
			end
			ST_DIV1: begin
				div_go = ~started_q;
				if (op_done) state_d = ST_DIV2;
			end
			ST_DIV2: begin
				div_go = ~started_q;
				if (op_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			mul_a_q <= PW'(mul_x);
			mul_b_q <= mul_y;
			mul_p_q <= '0;
		end else if (mul_busy_q) begin
			if (mul_b_q[0]) mul_p_q <= mul_p_q + mul_a_q;
			mul_a_q <= mul_a_q << 1;
			mul_b_q <= mul_b_q >> 1;
		end

		if (q_pop) begin
			dx_q    <= q_dx;
			dy_q    <= q_dy;
			flags_q <= q_flags;
			len_q   <= '0;
			time_q  <= '0;
		end
		if (op_done) begin
			unique case (state_q)
				ST_SQX:   sq_q   <= XW'(mul_p_q);
				ST_SQY:   sq_q   <= sq_q + XW'(mul_p_q);
				ST_ROOT:  len_q  <= len_sat;
				ST_MDA:   lhs_q  <= mul_p_q;
				ST_ROOTS: time_q <= root_time_sat;
				ST_DIV1:  time_q <= quo_sat;
				ST_DIV2:  time_q <= time_add[SEG_TIME_W] ? {SEG_TIME_W{1'b1}}
					: time_add[SEG_TIME_W-1:0];
				default: begin
				end
			endcase
		end
		if (out_load) begin
			segment_length <= len_q;
			segment_time   <= time_q;
			total_length   <= len_new;
			total_time     <= tsum_new;
			waypoint_count <= cnt_new;
			path_done      <= flags_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			mul_busy_q  <= 1'b0;
			mul_cnt_q   <= '0;
			speed_q     <= REG_RESET;
			accel_q     <= REG_RESET;
			len_sum_q   <= '0;
			time_sum_q  <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op_done) begin
				started_q <= 1'b0;
			end else if (mul_go || div_go || sqrt_go) begin
				started_q <= 1'b1;
			end
			if (mul_go) begin
				mul_busy_q <= 1'b1;
				mul_cnt_q  <= MCW'(MW);
			end else if (mul_busy_q) begin
				mul_cnt_q  <= mul_cnt_q - 1'b1;
				mul_busy_q <= (mul_cnt_q != MCW'(1));
			end
			if (cfg_we) begin
				if (cfg_index == REG_MAX_SPEED) begin
					speed_q <= (cfg_data == '0) ? REG_W'(1) : cfg_data;
				end else if (cfg_index == REG_MAX_ACCEL) begin
					accel_q <= (cfg_data == '0) ? REG_W'(1) : cfg_data;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				len_sum_q   <= flags_q.last ? '0 : len_new;
				time_sum_q  <= flags_q.last ? '0 : tsum_new;
				cnt_q       <= flags_q.last ? '0 : cnt_new;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/trapezoid_ramp_path_time_unit.sv =====
// A path's first point skips the arithmetic and goes straight to the result. A later point
// runs through the one-bit-per-cycle shift-add multiplier (four passes), the restoring divider
// and the digit square root, on a short segment and on a long one. The back end takes no new
// waypoint until it has finished the last one; a two-entry queue takes points meanwhile.
// Reset clears the queue, path totals and previous point, and sets both limits to 1.0.
`timescale 1ns / 1ps
module trapezoid_ramp_path_time_unit #(
	parameter int COORD_BITS = trp_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = trp_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [trp_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [trp_pkg::REG_W-1:0]               cfg_data,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// Fields from bit 0: point_x, point_y, zero padding.
	input  logic [((2 * COORD_BITS + 7) / 8) * 8-1:0] s_tdata,
	// Field: path_start.
	input  logic                                    s_tuser,
	input  logic                                    s_tlast,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// Fields from bit 0: segment_length, segment_time, total_length, total_time,
	// waypoint_count.
	output logic [trp_pkg::OUT_W-1:0]               m_tdata,
	output logic                                    m_tlast
);
	import trp_pkg::*;

	logic                  q_valid, q_pop;
	logic [COORD_BITS-1:0] q_dx, q_dy;
	trp_flags_t            q_flags;
	logic [SEG_LEN_W-1:0]  seg_len;
	logic [SEG_TIME_W-1:0] seg_time;
	logic [SUM_W-1:0]      tot_len, tot_time;
	logic [COUNT_W-1:0]    wp_count;

	trp_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.point_x(s_tdata[COORD_BITS-1:0]),
		.point_y(s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.path_start(s_tuser), .path_end(s_tlast),
		.q_valid(q_valid), .q_pop(q_pop), .q_dx(q_dx), .q_dy(q_dy), .q_flags(q_flags)
	);

	trp_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_valid(q_valid), .q_pop(q_pop), .q_dx(q_dx), .q_dy(q_dy), .q_flags(q_flags),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.segment_length(seg_len), .segment_time(seg_time),
		.total_length(tot_len), .total_time(tot_time),
		.waypoint_count(wp_count), .path_done(m_tlast)
	);

	assign m_tdata = {wp_count, tot_time, tot_len, seg_time, seg_len};

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the trapezoidal ramp path time unit.
`timescale 1ns / 1ps
module testbench;
	import trp_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0]    count;
		logic [SUM_W-1:0]      time_sum;
		logic [SUM_W-1:0]      len_sum;
		logic [SEG_TIME_W-1:0] seg_time;
		logic [SEG_LEN_W-1:0]  seg_len;
		logic                  done;
	} path_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tlast;

	trapezoid_ramp_path_time_unit i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state.
	logic [63:0] speed_lim, accel_lim;
	logic signed [63:0] last_x, last_y;
	bit have_last;
	logic [63:0] len_acc, time_acc, pts_acc;
	path_result_t pending_results[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	function automatic logic [63:0] floor_sqrt(input logic [127:0] val);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= val) r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] sat(input logic [127:0] v, input logic [63:0] mx);
		return (v > 128'(mx)) ? mx : v[63:0];
	endfunction

	function automatic logic [63:0] ramp_duration(input logic [63:0] d);
		logic [127:0] t1, t2;
		if (128'(d) * 128'(accel_lim) < 128'(speed_lim) * 128'(speed_lim)) begin
			return sat(128'(floor_sqrt((128'(d) << 34) / 128'(accel_lim))),
				(64'd1 << SEG_TIME_W) - 1);
		end
		t1 = 128'(sat((128'(speed_lim) << 16) / 128'(accel_lim),
			(64'd1 << SEG_TIME_W) - 1));
		t2 = 128'(sat((128'(d) << 16) / 128'(speed_lim), (64'd1 << SEG_TIME_W) - 1));
		return sat(t1 + t2, (64'd1 << SEG_TIME_W) - 1);
	endfunction

	task automatic predict_waypoint(input logic [31:0] px, input logic [31:0] py,
			input bit start, input bit fin);
		path_result_t r;
		logic signed [63:0] x, y;
		logic [63:0] dx, dy, dl, dt;
		x = 64'($signed(px));
		y = 64'($signed(py));
		dl = 0;
		dt = 0;
		if (start) begin
			have_last = 0; len_acc = 0; time_acc = 0; pts_acc = 0;
		end
		if (have_last) begin
			dx = (x > last_x) ? x - last_x : last_x - x;
			dy = (y > last_y) ? y - last_y : last_y - y;
			dl = sat(128'(floor_sqrt(128'(dx) * 128'(dx) + 128'(dy) * 128'(dy))),
				(64'd1 << SEG_LEN_W) - 1);
			dt = ramp_duration(dl);
		end
		len_acc = sat(128'(len_acc) + 128'(dl), (64'd1 << SUM_W) - 1);
		time_acc = sat(128'(time_acc) + 128'(dt), (64'd1 << SUM_W) - 1);
		pts_acc = sat(128'(pts_acc) + 1, 64'hFFFF_FFFF);
		last_x = x;
		last_y = y;
		have_last = 1;
		r.seg_len = dl[SEG_LEN_W-1:0];
		r.seg_time = dt[SEG_TIME_W-1:0];
		r.len_sum = len_acc[SUM_W-1:0];
		r.time_sum = time_acc[SUM_W-1:0];
		r.count = pts_acc[COUNT_W-1:0];
		r.done = fin;
		pending_results.push_back(r);
		if (fin) begin
			have_last = 0; len_acc = 0; time_acc = 0; pts_acc = 0;
		end
	endtask

	task automatic send_waypoint(input logic [31:0] px, input logic [31:0] py,
			input bit start, input bit fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		s_tuser <= start;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_waypoint(px, py, start, fin);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (val == 0) val = 1;
		if (idx == REG_MAX_SPEED) speed_lim = 64'(val);
		else accel_lim = 64'(val);
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		path_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata, m_tlast};
			if (pending_results.size() == 0) begin
				$display("%t unexpected transaction %h", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.seg_len !== want.seg_len)
					$display("%t segment_length exp %h got %h", $time, want.seg_len,
						got.seg_len);
				if (got.seg_time !== want.seg_time)
					$display("%t segment_time exp %h got %h", $time, want.seg_time,
						got.seg_time);
				if (got.len_sum !== want.len_sum)
					$display("%t total_length exp %h got %h", $time, want.len_sum,
						got.len_sum);
				if (got.time_sum !== want.time_sum)
					$display("%t total_time exp %h got %h", $time, want.time_sum,
						got.time_sum);
				if (got.count !== want.count)
					$display("%t waypoint_count exp %h got %h", $time, want.count,
						got.count);
				if (got.done !== want.done)
					$display("%t path_done exp %b got %b", $time, want.done, got.done);
				if (got !== want) errors++;
			end
		end
	end

	function automatic logic [31:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom_range(8192) - 4096;
			1: return $urandom_range(2000000) - 1000000;
			2: return $urandom();
			default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	task automatic test_directed();
		send_waypoint(0, 0, 1, 0);
		send_waypoint(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
		send_waypoint(32'h8000_0000, 32'h8000_0000, 0, 0);
		send_waypoint(32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
		send_waypoint(65536, 0, 0, 0);
		send_waypoint(65536, 1, 0, 0);
		send_waypoint(65536, 1, 0, 0);
		send_waypoint(0, 0, 1, 1);
		send_waypoint(3 << 16, 4 << 16, 1, 0);
		send_waypoint(0, 0, 0, 0);
		send_waypoint(100 << 16, 0, 0, 1);
	endtask

	task automatic run_random_paths(input int n_items);
		int left;
		int len;
		int mode;
		left = n_items;
		while (left > 0) begin
			len = $urandom_range(12, 1);
			mode = $urandom_range(3);
			for (int k = 0; k < len && left > 0; k++, left--) begin
				if ($urandom_range(9) == 0)
					send_waypoint(rand_coord(mode), rand_coord(mode),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				else
					send_waypoint(rand_coord(mode), rand_coord(mode), k == 0,
						k == len - 1);
			end
		end
	endtask

	task automatic test_limits();
		logic [31:0] sp[5] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd300000};
		logic [31:0] ac[5] = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd20000, 32'd65536};
		for (int i = 0; i < 5; i++) begin
			write_limit(REG_MAX_SPEED, sp[i]);
			write_limit(REG_MAX_ACCEL, ac[i]);
			run_random_paths(60);
		end
	endtask

	task automatic test_idling();
		send_idle_pct = 71; recv_stall_pct = 0; run_random_paths(400);
		send_idle_pct = 0; recv_stall_pct = 71; run_random_paths(400);
		send_idle_pct = 20; recv_stall_pct = 20; run_random_paths(400);
		send_idle_pct = 0; recv_stall_pct = 0; run_random_paths(400);
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_cycles = 3000;
		run_random_paths(10);
	endtask

	initial begin
		speed_lim = 64'(REG_RESET);
		accel_lim = 64'(REG_RESET);
		last_x = 0; last_y = 0; have_last = 0;
		len_acc = 0; time_acc = 0; pts_acc = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		test_idling();
		test_backpressure();
		wait_drained();
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/trp_pkg.sv
hdl/trp_front.sv
hdl/trp_div.sv
hdl/trp_sqrt.sv
hdl/trp_back.sv
hdl/trapezoid_ramp_path_time_unit.sv
verif/testbench.sv
